// ===== rtl/rv32i_core_step_core_macros.svh =====
// Assertion macros for the RV32I step core.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef RV32I_CORE_STEP_CORE_MACROS_SVH
`define RV32I_CORE_STEP_CORE_MACROS_SVH
// same-cycle implication
`define RVCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvcs check failed");
// next-cycle implication
`define RVCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvcs check failed");
`endif

// ===== rtl/rvcs_pkg.sv =====
// Shared constants, types and functions of the RV32I step core.
// No dependencies.
package rvcs_pkg;
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int SP_WORD   = 0;
  localparam int PC_WORD   = 1;

  localparam logic [1:0] REQ_IMG   = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic [1:0] CFG_MEM_BYTES = 2'd0;
  localparam logic [1:0] CFG_TMO_EN    = 2'd1;
  localparam logic [1:0] CFG_TMO_CYC   = 2'd2;
  localparam logic [1:0] CFG_INT_PER   = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ECALL = 3'd1;
  localparam logic [2:0] ST_EBRK  = 3'd2;
  localparam logic [2:0] ST_FENCE = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;
  localparam logic [2:0] ST_PCR   = 3'd5;
  localparam logic [2:0] ST_TMO   = 3'd6;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [2:0] RAM_NONE   = 3'd0;
  localparam logic [2:0] RAM_IMG_WR = 3'd1;
  localparam logic [2:0] RAM_RD_SP  = 3'd2;
  localparam logic [2:0] RAM_RD_PC  = 3'd3;
  localparam logic [2:0] RAM_RD_LO  = 3'd4;
  localparam logic [2:0] RAM_RD_HI  = 3'd5;
  localparam logic [2:0] RAM_WR_LO  = 3'd6;
  localparam logic [2:0] RAM_WR_HI  = 3'd7;

  localparam logic [31:0] INT_PER_DEF = 32'd500;

  typedef struct packed {
    logic       accept;
    logic [2:0] ram_op;
    logic       cap_lo;
    logic       cap_hi;
    logic       set_sp;
    logic       set_pc;
    logic       step_go;
    logic       tmo;
    logic       dec;
    logic       exec;
    logic       bad;
    logic       load_wb;
    logic       commit;
    logic       div_step;
    logic       due;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic tmo_hit;
    logic bad;
    logic is_load;
    logic is_store;
    logic oor;
    logic div_last;
    logic out_valid;
  } stat_t;

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    case (f3)
      3'd0: r = alt ? a - b : a + b;
      3'd1: r = a << b[4:0];
      3'd2: r = {31'd0, $signed(a) < $signed(b)};
      3'd3: r = {31'd0, a < b};
      3'd4: r = a ^ b;
      3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/rvcs_if.sv =====
// Valid/ready channel interfaces of the RV32I step core.
// Depends on nothing.
interface rvcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] word_index;
  logic [31:0] word_data;
  modport source (output valid, req_type, word_index, word_data, input ready);
  modport sink (input valid, req_type, word_index, word_data, output ready);
endinterface

interface rvcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] pc_now;
  logic        int_due;
  logic        store_done;
  logic [31:0] store_addr;
  modport source (output valid, status, pc_now, int_due, store_done, store_addr, input ready);
  modport sink (input valid, status, pc_now, int_due, store_done, store_addr, output ready);
endinterface

// ===== rtl/rvcs_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module rvcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/rvcs_ctrl.sv =====
// Sequencer of the RV32I step core: walks each item through its phases.
// Depends on rvcs_pkg.
module rvcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic              out_ready,
  input  rvcs_pkg::stat_t   stat,
  output rvcs_pkg::cmd_t    cmd
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ST0  = 5'd1;
  localparam logic [4:0] S_ST1  = 5'd2;
  localparam logic [4:0] S_ST2  = 5'd3;
  localparam logic [4:0] S_FA   = 5'd4;
  localparam logic [4:0] S_FB   = 5'd5;
  localparam logic [4:0] S_FC   = 5'd6;
  localparam logic [4:0] S_DC   = 5'd7;
  localparam logic [4:0] S_EX   = 5'd8;
  localparam logic [4:0] S_PX   = 5'd9;
  localparam logic [4:0] S_MA   = 5'd10;
  localparam logic [4:0] S_MB   = 5'd11;
  localparam logic [4:0] S_MC   = 5'd12;
  localparam logic [4:0] S_LW   = 5'd13;
  localparam logic [4:0] S_SW0  = 5'd14;
  localparam logic [4:0] S_SW1  = 5'd15;
  localparam logic [4:0] S_CM   = 5'd16;
  localparam logic [4:0] S_DV   = 5'd17;
  localparam logic [4:0] S_DE   = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;

  logic [4:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_req_type)
            rvcs_pkg::REQ_IMG: begin
              cmd.ram_op = rvcs_pkg::RAM_IMG_WR;
              state_nxt  = S_FIN;
            end
            rvcs_pkg::REQ_START: state_nxt = S_ST0;
            rvcs_pkg::REQ_STEP: begin
              if (stat.halted) begin
                state_nxt = S_FIN;
              end else if (stat.tmo_hit) begin
                cmd.tmo   = 1'b1;
                state_nxt = S_FIN;
              end else begin
                cmd.step_go = 1'b1;
                state_nxt   = S_FA;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_ST0: begin
        cmd.ram_op = rvcs_pkg::RAM_RD_SP;
        state_nxt  = S_ST1;
      end
      S_ST1: begin
        cmd.ram_op = rvcs_pkg::RAM_RD_PC;
        cmd.set_sp = 1'b1;
        state_nxt  = S_ST2;
      end
      S_ST2: begin
        cmd.set_pc = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FA: begin
        cmd.ram_op = rvcs_pkg::RAM_RD_LO;
        state_nxt  = S_FB;
      end
      S_FB: begin
        cmd.ram_op = rvcs_pkg::RAM_RD_HI;
        cmd.cap_lo = 1'b1;
        state_nxt  = S_FC;
      end
      S_FC: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = S_DC;
      end
      S_DC: begin
        cmd.dec   = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.exec  = 1'b1;
        state_nxt = S_PX;
      end
      S_PX: begin
        if (stat.bad) begin
          cmd.bad   = 1'b1;
          state_nxt = S_FIN;
        end else if (stat.is_load || stat.is_store) begin
          state_nxt = S_MA;
        end else begin
          state_nxt = S_CM;
        end
      end
      S_MA: begin
        cmd.ram_op = rvcs_pkg::RAM_RD_LO;
        state_nxt  = S_MB;
      end
      S_MB: begin
        cmd.ram_op = rvcs_pkg::RAM_RD_HI;
        cmd.cap_lo = 1'b1;
        state_nxt  = S_MC;
      end
      S_MC: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = stat.is_load ? S_LW : S_SW0;
      end
      S_LW: begin
        cmd.load_wb = 1'b1;
        state_nxt   = S_CM;
      end
      S_SW0: begin
        cmd.ram_op = rvcs_pkg::RAM_WR_LO;
        state_nxt  = S_SW1;
      end
      S_SW1: begin
        cmd.ram_op = rvcs_pkg::RAM_WR_HI;
        state_nxt  = S_CM;
      end
      S_CM: begin
        cmd.commit = 1'b1;
        state_nxt  = stat.oor ? S_FIN : S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DE;
        end
      end
      S_DE: begin
        cmd.due   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== rtl/rvcs_dp.sv =====
// Datapath of the RV32I step core: config, pc, counters, register file,
// word memory, decode/execute, serial remainder and result register.
// Depends on rvcs_pkg and rvcs_ram.
module rvcs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [11:0]       in_word_index,
  input  logic [31:0]       in_word_data,
  input  logic              out_ready,
  input  rvcs_pkg::cmd_t    cmd,
  output rvcs_pkg::stat_t   stat,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [31:0]       out_pc_now,
  output logic              out_int_due,
  output logic              out_store_done,
  output logic [31:0]       out_store_addr
);
  localparam int AW = rvcs_pkg::MEM_AW;

  logic [14:0] mbytes_r;
  logic        tmo_en_r;
  logic [30:0] tmo_cyc_r;
  logic [31:0] per_r;

  logic [31:0] pc_r, cyc_r, lo_r, hi_r, ins_r, addr_r, next_r, wbv_r, b_r;
  logic        halted_r, wb_r, bad_r, ld_r, st_r;
  logic [4:0]  rs1_r, rs2_r, rd_r, cnt_r;
  logic [2:0]  f3_r, env_r, stat_r;
  logic        sdone_r, due_r;
  logic [31:0] saddr_r, rem_r;
  logic [31:0] vld_r;
  logic        ov_r, odue_r, osd_r;
  logic [2:0]  ostat_r;
  logic [31:0] opc_r, osa_r;

  // word memory
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [31:0]   ram_wd, ram_q;
  logic [AW-1:0] wlo, whi;
  logic [63:0]   pair, win, mask64, data64, merged;
  logic [7:0]    bm, bm_sh;

  assign wlo  = addr_r[AW+1:2];
  assign whi  = wlo + AW'(1);
  assign pair = {hi_r, lo_r};
  assign win  = pair >> {addr_r[1:0], 3'b000};

  always_comb begin
    case (f3_r[1:0])
      2'd0:    bm = 8'h01;
      2'd1:    bm = 8'h03;
      default: bm = 8'h0f;
    endcase
    bm_sh  = bm << addr_r[1:0];
    for (int i = 0; i < 8; i++) begin
      mask64[i*8 +: 8] = {8{bm_sh[i]}};
    end
    data64 = {32'd0, b_r} << {addr_r[1:0], 3'b000};
    merged = (pair & ~mask64) | (data64 & mask64);
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = wlo;
    ram_wd   = merged[31:0];
    case (cmd.ram_op)
      rvcs_pkg::RAM_IMG_WR: begin
        ram_we   = 1'b1;
        ram_addr = in_word_index[AW-1:0];
        ram_wd   = in_word_data;
      end
      rvcs_pkg::RAM_RD_SP: ram_addr = AW'(rvcs_pkg::SP_WORD);
      rvcs_pkg::RAM_RD_PC: ram_addr = AW'(rvcs_pkg::PC_WORD);
      rvcs_pkg::RAM_RD_LO: ram_addr = wlo;
      rvcs_pkg::RAM_RD_HI: ram_addr = whi;
      rvcs_pkg::RAM_WR_LO: begin
        ram_we = 1'b1;
      end
      rvcs_pkg::RAM_WR_HI: begin
        ram_we   = 1'b1;
        ram_addr = whi;
        ram_wd   = merged[63:32];
      end
      default: ram_addr = wlo;
    endcase
  end

  rvcs_ram #(.WIDTH(32), .DEPTH(rvcs_pkg::MEM_WORDS)) u_mem (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_q)
  );

  // register file: two copies, one per source operand
  logic        rf_we;
  logic [4:0]  rf_wa, rfa_addr, rfb_addr;
  logic [31:0] rf_wd, rfa_q, rfb_q;

  always_comb begin
    rf_we = 1'b0;
    rf_wa = rd_r;
    rf_wd = wbv_r;
    if (cmd.set_sp) begin
      rf_we = 1'b1;
      rf_wa = 5'd2;
      rf_wd = ram_q;
    end else if (cmd.commit && wb_r && rd_r != 5'd0) begin
      rf_we = 1'b1;
    end
    rfa_addr = rf_we ? rf_wa : win[19:15];
    rfb_addr = rf_we ? rf_wa : win[24:20];
  end

  rvcs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .addr(rfa_addr), .wdata(rf_wd), .rdata(rfa_q)
  );
  rvcs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .addr(rfb_addr), .wdata(rf_wd), .rdata(rfb_q)
  );

  // execute
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, x_next, x_val, x_addr;
  logic        x_wb, x_bad, x_ld, x_st, take;
  logic [2:0]  x_env;

  always_comb begin
    op    = ins_r[6:0];
    f3    = ins_r[14:12];
    f7    = ins_r[31:25];
    a     = vld_r[rs1_r] ? rfa_q : 32'd0;
    b     = vld_r[rs2_r] ? rfb_q : 32'd0;
    imm_i = {{20{ins_r[31]}}, ins_r[31:20]};
    imm_s = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    imm_b = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    imm_j = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
    x_next = pc_r + 32'd4;
    x_val  = 32'd0;
    x_addr = a + imm_i;
    x_wb   = 1'b0;
    x_bad  = 1'b0;
    x_ld   = 1'b0;
    x_st   = 1'b0;
    x_env  = rvcs_pkg::ST_OK;
    take   = 1'b0;
    case (op)
      rvcs_pkg::OP_LUI: begin
        x_wb  = 1'b1;
        x_val = {ins_r[31:12], 12'd0};
      end
      rvcs_pkg::OP_AUIPC: begin
        x_wb  = 1'b1;
        x_val = pc_r + {ins_r[31:12], 12'd0};
      end
      rvcs_pkg::OP_JAL: begin
        x_wb   = 1'b1;
        x_val  = pc_r + 32'd4;
        x_next = pc_r + imm_j;
      end
      rvcs_pkg::OP_JALR: begin
        if (f3 != 3'd0) begin
          x_bad = 1'b1;
        end else begin
          x_wb   = 1'b1;
          x_val  = pc_r + 32'd4;
          x_next = {x_addr[31:1], 1'b0};
        end
      end
      rvcs_pkg::OP_BRANCH: begin
        case (f3)
          3'd0:    take = (a == b);
          3'd1:    take = (a != b);
          3'd4:    take = ($signed(a) < $signed(b));
          3'd5:    take = !($signed(a) < $signed(b));
          3'd6:    take = (a < b);
          3'd7:    take = (a >= b);
          default: x_bad = 1'b1;
        endcase
        if (take) begin
          x_next = pc_r + imm_b;
        end
      end
      rvcs_pkg::OP_LOAD: begin
        x_wb = 1'b1;
        x_ld = 1'b1;
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
          x_bad = 1'b1;
        end
      end
      rvcs_pkg::OP_STORE: begin
        x_addr = a + imm_s;
        if (f3 > 3'd2) begin
          x_bad = 1'b1;
        end else begin
          x_st = 1'b1;
        end
      end
      rvcs_pkg::OP_IMM: begin
        if ((f3 == 3'd1 && f7 != 7'd0) ||
            (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20)) begin
          x_bad = 1'b1;
        end else begin
          x_wb = 1'b1;
          if (f3 == 3'd1 || f3 == 3'd5) begin
            x_val = rvcs_pkg::alu(f3, f7 == 7'h20, a, {27'd0, ins_r[24:20]});
          end else begin
            x_val = rvcs_pkg::alu(f3, 1'b0, a, imm_i);
          end
        end
      end
      rvcs_pkg::OP_REG: begin
        if (f7 == 7'd0) begin
          x_wb  = 1'b1;
          x_val = rvcs_pkg::alu(f3, 1'b0, a, b);
        end else if (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) begin
          x_wb  = 1'b1;
          x_val = rvcs_pkg::alu(f3, 1'b1, a, b);
        end else begin
          x_bad = 1'b1;
        end
      end
      rvcs_pkg::OP_FENCE: begin
        if (f3 == 3'd0) x_env = rvcs_pkg::ST_FENCE;
        else x_bad = 1'b1;
      end
      rvcs_pkg::OP_SYSTEM: begin
        if (f3 == 3'd0 && ins_r[31:20] == 12'd0) x_env = rvcs_pkg::ST_ECALL;
        else if (f3 == 3'd0 && ins_r[31:20] == 12'd1) x_env = rvcs_pkg::ST_EBRK;
        else x_bad = 1'b1;
      end
      default: x_bad = 1'b1;
    endcase
  end

  // load extraction
  logic [31:0] ld_val;
  always_comb begin
    case (f3_r)
      3'd0:    ld_val = {{24{win[7]}}, win[7:0]};
      3'd1:    ld_val = {{16{win[15]}}, win[15:0]};
      3'd4:    ld_val = {24'd0, win[7:0]};
      3'd5:    ld_val = {16'd0, win[15:0]};
      default: ld_val = win[31:0];
    endcase
  end

  // serial remainder of cycle count by the interrupt period
  logic [31:0] per;
  logic [32:0] rem_t;
  assign per   = (per_r == 32'd0) ? rvcs_pkg::INT_PER_DEF : per_r;
  assign rem_t = {rem_r, cyc_r[~cnt_r]};

  assign stat.halted    = halted_r;
  assign stat.tmo_hit   = tmo_en_r && (cyc_r == {1'b0, tmo_cyc_r});
  assign stat.bad       = bad_r;
  assign stat.is_load   = ld_r;
  assign stat.is_store  = st_r;
  assign stat.oor       = (next_r >= {17'd0, mbytes_r});
  assign stat.div_last  = (cnt_r == 5'd31);
  assign stat.out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbytes_r  <= 15'd16384;
      tmo_en_r  <= 1'b0;
      tmo_cyc_r <= 31'h7fffffff;
      per_r     <= rvcs_pkg::INT_PER_DEF;
      pc_r      <= 32'd0;
      cyc_r     <= 32'd0;
      halted_r  <= 1'b0;
      vld_r     <= 32'd0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rvcs_pkg::CFG_MEM_BYTES: mbytes_r  <= cfg_data[14:0];
          rvcs_pkg::CFG_TMO_EN:    tmo_en_r  <= cfg_data[0];
          rvcs_pkg::CFG_TMO_CYC:   tmo_cyc_r <= cfg_data[30:0];
          default:                 per_r     <= cfg_data;
        endcase
      end
      if (rf_we) begin
        vld_r[rf_wa] <= 1'b1;
      end
      if (cmd.step_go) begin
        cyc_r <= cyc_r + 32'd1;
      end
      if (cmd.set_pc) begin
        pc_r     <= ram_q;
        halted_r <= 1'b0;
      end
      if (cmd.tmo || cmd.bad) begin
        halted_r <= 1'b1;
      end
      if (cmd.commit) begin
        pc_r <= next_r;
        if (stat.oor) begin
          halted_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      stat_r  <= cmd.tmo ? rvcs_pkg::ST_TMO : rvcs_pkg::ST_OK;
      sdone_r <= 1'b0;
      saddr_r <= 32'd0;
      due_r   <= 1'b0;
    end
    if (cmd.bad) stat_r <= rvcs_pkg::ST_BAD;
    if (cmd.step_go) addr_r <= pc_r;
    if (cmd.cap_lo) lo_r <= ram_q;
    if (cmd.cap_hi) hi_r <= ram_q;
    if (cmd.dec) begin
      ins_r <= win[31:0];
      rs1_r <= win[19:15];
      rs2_r <= win[24:20];
    end
    if (cmd.exec) begin
      next_r <= x_next;
      wbv_r  <= x_val;
      wb_r   <= x_wb;
      bad_r  <= x_bad;
      ld_r   <= x_ld;
      st_r   <= x_st;
      env_r  <= x_env;
      f3_r   <= f3;
      rd_r   <= ins_r[11:7];
      b_r    <= b;
      addr_r <= x_addr;
    end
    if (cmd.load_wb) wbv_r <= ld_val;
    if (cmd.ram_op == rvcs_pkg::RAM_WR_HI) begin
      sdone_r <= 1'b1;
      saddr_r <= addr_r;
    end
    if (cmd.commit) begin
      stat_r <= stat.oor ? rvcs_pkg::ST_PCR : env_r;
      rem_r  <= 32'd0;
      cnt_r  <= 5'd0;
    end
    if (cmd.div_step) begin
      rem_r <= (rem_t >= {1'b0, per}) ? 32'(rem_t - {1'b0, per}) : rem_t[31:0];
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.due) due_r <= (rem_r == 32'd0);
    if (cmd.out_load) begin
      ostat_r <= stat_r;
      opc_r   <= pc_r;
      odue_r  <= due_r;
      osd_r   <= sdone_r;
      osa_r   <= saddr_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = ostat_r;
  assign out_pc_now     = opc_r;
  assign out_int_due    = odue_r;
  assign out_store_done = osd_r;
  assign out_store_addr = osa_r;
endmodule

// ===== rtl/rv32i_core_step_core.sv =====
// A step runs a serial remainder pass for the interrupt check; one item at a time.
// Pc out of range or invalid instruction ends the step early (no remainder pass).
// Reset (synchronous, rst_n low): pc, cycle count, halt flag, output valid flag and config to reset
// values; the register file reads zero until written; word memory holds no reset value.
// Depends on rvcs_pkg, rvcs_if, rvcs_ram, rvcs_ctrl, rvcs_dp and the macros header.
`include "rv32i_core_step_core_macros.svh"
module rv32i_core_step_core (
  input  logic         clk,
  input  logic         rst_n,
  rvcs_in_if.sink      in,
  rvcs_out_if.source   out,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  rvcs_pkg::cmd_t  cmd;
  rvcs_pkg::stat_t stat;

  rvcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in.valid), .in_ready(in.ready), .in_req_type(in.req_type),
    .out_ready(out.ready), .stat(stat), .cmd(cmd)
  );

  rvcs_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_word_index(in.word_index), .in_word_data(in.word_data),
    .out_ready(out.ready), .cmd(cmd), .stat(stat),
    .out_valid(out.valid), .out_status(out.status), .out_pc_now(out.pc_now),
    .out_int_due(out.int_due), .out_store_done(out.store_done),
    .out_store_addr(out.store_addr)
  );

  `RVCS_ASSERT_NOW(a_no_load_on_accept, in.valid && in.ready, !cmd.out_load)
  `RVCS_ASSERT_NOW(a_hi_after_lo, cmd.ram_op == rvcs_pkg::RAM_WR_HI,
                   $past(cmd.ram_op) == rvcs_pkg::RAM_WR_LO)
  `RVCS_ASSERT_NOW(a_tmo_clean, out.valid && out.status == rvcs_pkg::ST_TMO,
                   !out.int_due && !out.store_done)
  `RVCS_ASSERT_NEXT(a_out_loads, cmd.out_load, out.valid)
endmodule
